### rtl/eva_pkg.sv
// Shared types and constants for the eased value animator.
package eva_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADD,
    ST_PREP,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_FIN
  } eva_state_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSHOOT = 1'b1;

  // Curve codes.
  localparam int CURVE_W = 3;
  localparam logic [CURVE_W-1:0] CURVE_LINEAR = 3'd0;
  localparam logic [CURVE_W-1:0] CURVE_IN     = 3'd1;
  localparam logic [CURVE_W-1:0] CURVE_OUT    = 3'd2;
  localparam logic [CURVE_W-1:0] CURVE_INOUT  = 3'd3;
  localparam logic [CURVE_W-1:0] CURVE_OUTIN  = 3'd4;
  localparam logic [CURVE_W-1:0] CURVE_RESET  = CURVE_IN;

  // Fixed point: progress is Q1.16, easing factors fit a signed 23-bit word.
  localparam int FRAC_BITS = 16;
  localparam int PROG_W    = FRAC_BITS + 1;
  localparam int FACT_W    = 23;
  localparam int X_W       = FRAC_BITS + 2;
  localparam logic [PROG_W-1:0] ONE_Q16 = 17'd65536;
  localparam int QCNT_W    = 4;

endpackage

### rtl/eva_in_if.sv
// Request channel carrying tick and retarget items.
interface eva_in_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH  = 16
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [TIME_WIDTH-1:0]         elapsed;
  logic signed [VALUE_WIDTH-1:0] target;
  logic [TIME_WIDTH-1:0]         span;

  modport source (output valid, mode, elapsed, target, span, input ready);
  modport sink   (input valid, mode, elapsed, target, span, output ready);
endinterface

### rtl/eva_out_if.sv
// Result channel carrying the animated value.
interface eva_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          finished;

  modport source (output valid, value, finished, input ready);
  modport sink   (input valid, value, finished, output ready);
endinterface

### rtl/eva_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
module eva_mul #(
  parameter int A_WIDTH = 33,
  parameter int B_WIDTH = 23
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [A_WIDTH-1:0]           a,
  input  logic signed [B_WIDTH-1:0]           b,
  output logic                                done,
  output logic signed [A_WIDTH+B_WIDTH-1:0]   p
);
  localparam int STEPS = B_WIDTH - 1;
  localparam int CNT_W = $clog2(B_WIDTH);
  localparam int ACC_W = A_WIDTH + B_WIDTH - 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [A_WIDTH-1:0] amag_r, amag_nxt;
  logic [STEPS-1:0] bmag_r, bmag_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             neg_r, neg_nxt;
  logic [A_WIDTH:0] sum;
  logic [A_WIDTH-1:0] a_abs;
  logic [B_WIDTH-1:0] b_abs;

  always_comb begin
    a_abs    = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
    b_abs    = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);
    sum      = {1'b0, acc_r[ACC_W-1:STEPS]} + (bmag_r[0] ? {1'b0, amag_r} : '0);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    amag_nxt = amag_r;
    bmag_nxt = bmag_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS - 1);
      amag_nxt = a_abs;
      bmag_nxt = b_abs[STEPS-1:0];
      acc_nxt  = '0;
      neg_nxt  = a[A_WIDTH-1] ^ b[B_WIDTH-1];
    end else if (busy_r) begin
      // Add the multiplicand into the top and shift the product right.
      acc_nxt  = {sum, acc_r[STEPS-1:1]};
      bmag_nxt = bmag_r >> 1;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    amag_r <= amag_nxt;
    bmag_r <= bmag_nxt;
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
  end

  assign done = done_r;
  assign p    = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});

endmodule

### rtl/eased_value_animator.sv
// Top level of the eased value animator.
//
// Requests arrive on in_ch: mode 1 retargets (the current value becomes the
// start, target and span become the new end and duration), mode 0 is a time
// tick carrying elapsed. Every request yields exactly one result on out_ch
// with the current value and a finished flag. The user sets curve and
// overshoot through the cfg_ write port while no request is in flight.
//
// The block itself does not enforce that rule. One request is worked on at
// a time. A retarget, a tick with zero duration or a tick whose elapsed time
// covers the whole duration goes straight to the finish state. Other ticks
// run a restoring divider for elapsed/duration; if progress then saturates,
// no product is formed, else the bit-serial 22-step multiplier follows: one
// product for the linear curve, four for the back-easing curves. The result
// sits in an output register, so the next request can be accepted while the
// result waits; a stalled receiver holds only the following result.
// Reset is synchronous: curve becomes back-ease in, overshoot zero and all
// animation state zero, so a first tick reports finished at zero.
module eased_value_animator #(
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  eva_in_if.sink                           in_ch,
  eva_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [eva_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [eva_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int VW = VALUE_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int DW = VW + 1;
  localparam int FW = eva_pkg::FACT_W;
  localparam int AW = (DW > FW) ? DW : FW;
  localparam int PW = AW + FW;
  localparam int FB = eva_pkg::FRAC_BITS;
  localparam int PG = eva_pkg::PROG_W;
  localparam int XW = eva_pkg::X_W;

  eva_pkg::eva_state_t state_r, state_nxt;

  logic [eva_pkg::CURVE_W-1:0] curve_r, curve_nxt;
  logic [15:0]           over_r, over_nxt;
  logic signed [VW-1:0]  cur_r, cur_nxt;
  logic signed [VW-1:0]  start_r, start_nxt;
  logic signed [VW-1:0]  end_r, end_nxt;
  logic [PG-1:0]         prog_r, prog_nxt;
  logic [TW-1:0]         dur_r, dur_nxt;
  logic [TW:0]           rem_r, rem_nxt;
  logic [FB-1:0]         quo_r, quo_nxt;
  logic [eva_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [VW-1:0]  seg_s_r, seg_s_nxt;
  logic signed [VW-1:0]  seg_e_r, seg_e_nxt;
  logic signed [XW-1:0]  x_r, x_nxt;
  logic signed [FW-1:0]  x2_r, x2_nxt;
  logic                  ein_r, ein_nxt;
  logic                  lin_r, lin_nxt;
  logic                  issue_r, issue_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [VW-1:0]  out_value_r, out_value_nxt;
  logic                  out_fin_r, out_fin_nxt;

  logic                  in_acc;
  logic                  slot_free;
  logic                  tick_short;
  logic [TW:0]           r2;
  logic                  ge;
  logic [PG:0]           psum;
  logic [FB-1:0]         t;
  logic [FB-1:0]         tt;
  logic                  split;
  logic signed [DW-1:0]  dfull;
  logic signed [VW-1:0]  mid;
  logic signed [PW-1:0]  sh;
  logic signed [FW-1:0]  shf;
  logic signed [FW-1:0]  mval;
  logic signed [FW-1:0]  m1;
  logic signed [FW-1:0]  inner;
  logic signed [FW-1:0]  fct;
  logic signed [DW-1:0]  dseg;
  logic signed [PW-1:0]  vsum;
  logic signed [VW-1:0]  vsat;
  logic signed [AW-1:0]  mul_a;
  logic signed [FW-1:0]  mul_b;
  logic                  mul_done;
  logic signed [PW-1:0]  mul_p;
  logic                  in_mul_nxt;

  eva_mul #(.A_WIDTH(AW), .B_WIDTH(FW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (issue_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign tick_short = (dur_r == '0) || (in_ch.elapsed >= dur_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      eva_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.mode || tick_short) state_nxt = eva_pkg::ST_FIN;
          else state_nxt = eva_pkg::ST_DIV;
        end
      end
      eva_pkg::ST_DIV: begin
        if (cnt_r == '0) state_nxt = eva_pkg::ST_ADD;
      end
      eva_pkg::ST_ADD: state_nxt = eva_pkg::ST_PREP;
      eva_pkg::ST_PREP: begin
        priority if (prog_r == eva_pkg::ONE_Q16) state_nxt = eva_pkg::ST_FIN;
        else if (lin_nxt) state_nxt = eva_pkg::ST_MUL4;
        else state_nxt = eva_pkg::ST_MUL1;
      end
      eva_pkg::ST_MUL1: if (mul_done) state_nxt = eva_pkg::ST_MUL2;
      eva_pkg::ST_MUL2: if (mul_done) state_nxt = eva_pkg::ST_MUL3;
      eva_pkg::ST_MUL3: if (mul_done) state_nxt = eva_pkg::ST_MUL4;
      eva_pkg::ST_MUL4: if (mul_done) state_nxt = eva_pkg::ST_FIN;
      eva_pkg::ST_FIN: if (slot_free) state_nxt = eva_pkg::ST_IDLE;
      default: state_nxt = eva_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ch.ready     = (state_r == eva_pkg::ST_IDLE);
    out_ch.valid    = out_valid_r;
    out_ch.value    = out_value_r;
    out_ch.finished = out_fin_r;
  end

  // Arithmetic shared by the multiply steps.
  always_comb begin
    sh    = mul_p >>> FB;
    shf   = sh[FW-1:0];
    mval  = $signed(FW'({over_r, 4'b0000}));
    m1    = mval + $signed(FW'(eva_pkg::ONE_Q16));
    inner = ein_r ? (shf - mval) : (shf + mval);
    if (lin_r) fct = FW'(x_r);
    else if (ein_r) fct = shf;
    else fct = shf + $signed(FW'(eva_pkg::ONE_Q16));
    dseg  = DW'(seg_e_r) - DW'(seg_s_r);
    unique case (state_r)
      eva_pkg::ST_MUL1: begin
        mul_a = AW'(x_r);
        mul_b = FW'(x_r);
      end
      eva_pkg::ST_MUL2: begin
        mul_a = AW'(m1);
        mul_b = FW'(x_r);
      end
      eva_pkg::ST_MUL3: begin
        mul_a = AW'(inner);
        mul_b = x2_r;
      end
      default: begin
        mul_a = AW'(dseg);
        mul_b = fct;
      end
    endcase
    vsum = PW'(seg_s_r) + sh;
    // Saturate when the bits above the value's sign bit disagree with it.
    if (vsum[PW-1:VW-1] == '0 || vsum[PW-1:VW-1] == '1) vsat = vsum[VW-1:0];
    else if (vsum[PW-1]) vsat = {1'b1, {(VW-1){1'b0}}};
    else vsat = {1'b0, {(VW-1){1'b1}}};
  end

  // Datapath next values.
  always_comb begin
    curve_nxt     = curve_r;
    over_nxt      = over_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    prog_nxt      = prog_r;
    dur_nxt       = dur_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    seg_s_nxt     = seg_s_r;
    seg_e_nxt     = seg_e_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    ein_nxt       = ein_r;
    lin_nxt       = lin_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_fin_nxt   = out_fin_r;

    r2    = {rem_r[TW-1:0], 1'b0};
    ge    = (r2 >= {1'b0, dur_r});
    psum  = {1'b0, prog_r} + (PG+1)'(quo_r);
    t     = prog_r[FB-1:0];
    split = (curve_r == eva_pkg::CURVE_INOUT) || (curve_r == eva_pkg::CURVE_OUTIN);
    // Both halves of a split curve run at 2t with the top bit dropped.
    tt    = split ? {t[FB-2:0], 1'b0} : t;
    dfull = DW'(end_r) - DW'(start_r);
    mid   = start_r + VW'(dfull >>> 1);

    if (cfg_we) begin
      unique case (cfg_idx)
        eva_pkg::CFG_CURVE:     curve_nxt = cfg_data[eva_pkg::CURVE_W-1:0];
        eva_pkg::CFG_OVERSHOOT: over_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      eva_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode) begin
            start_nxt = cur_r;
            end_nxt   = in_ch.target;
            dur_nxt   = in_ch.span;
            prog_nxt  = '0;
          end else if (tick_short) begin
            prog_nxt = eva_pkg::ONE_Q16;
            cur_nxt  = end_r;
          end else begin
            rem_nxt = {1'b0, in_ch.elapsed};
            quo_nxt = '0;
            cnt_nxt = '1;
          end
        end
      end
      eva_pkg::ST_DIV: begin
        rem_nxt = ge ? (r2 - {1'b0, dur_r}) : r2;
        quo_nxt = {quo_r[FB-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
      end
      eva_pkg::ST_ADD: begin
        prog_nxt = (psum >= (PG+1)'(eva_pkg::ONE_Q16)) ? eva_pkg::ONE_Q16 : psum[PG-1:0];
      end
      eva_pkg::ST_PREP: begin
        ein_nxt = 1'b0;
        lin_nxt = 1'b0;
        unique case (curve_r)
          eva_pkg::CURVE_LINEAR: lin_nxt = 1'b1;
          eva_pkg::CURVE_IN:     ein_nxt = 1'b1;
          eva_pkg::CURVE_OUT:    ein_nxt = 1'b0;
          eva_pkg::CURVE_INOUT:  ein_nxt = !t[FB-1];
          eva_pkg::CURVE_OUTIN:  ein_nxt = t[FB-1];
          default:               lin_nxt = 1'b1;
        endcase
        if (lin_nxt || ein_nxt) x_nxt = $signed(XW'(tt));
        else x_nxt = $signed(XW'(tt)) - $signed(XW'(eva_pkg::ONE_Q16));
        if (!split) begin
          seg_s_nxt = start_r;
          seg_e_nxt = end_r;
        end else if (!t[FB-1]) begin
          seg_s_nxt = start_r;
          seg_e_nxt = mid;
        end else begin
          seg_s_nxt = mid;
          seg_e_nxt = end_r;
        end
        if (prog_r == eva_pkg::ONE_Q16) cur_nxt = end_r;
      end
      eva_pkg::ST_MUL1: if (mul_done) x2_nxt = shf;
      eva_pkg::ST_MUL2: ;
      eva_pkg::ST_MUL3: ;
      eva_pkg::ST_MUL4: if (mul_done) cur_nxt = vsat;
      eva_pkg::ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = cur_r;
          out_fin_nxt   = (prog_r == eva_pkg::ONE_Q16) && (cur_r == end_r);
        end
      end
      default: ;
    endcase

    in_mul_nxt = (state_nxt == eva_pkg::ST_MUL1) || (state_nxt == eva_pkg::ST_MUL2) ||
                 (state_nxt == eva_pkg::ST_MUL3) || (state_nxt == eva_pkg::ST_MUL4);
    issue_nxt  = in_mul_nxt && (state_nxt != state_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eva_pkg::ST_IDLE;
      curve_r     <= eva_pkg::CURVE_RESET;
      over_r      <= '0;
      cur_r       <= '0;
      start_r     <= '0;
      end_r       <= '0;
      prog_r      <= '0;
      dur_r       <= '0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      curve_r     <= curve_nxt;
      over_r      <= over_nxt;
      cur_r       <= cur_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      prog_r      <= prog_nxt;
      dur_r       <= dur_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    seg_s_r     <= seg_s_nxt;
    seg_e_r     <= seg_e_nxt;
    x_r         <= x_nxt;
    x2_r        <= x2_nxt;
    ein_r       <= ein_nxt;
    lin_r       <= lin_nxt;
    out_value_r <= out_value_nxt;
    out_fin_r   <= out_fin_nxt;
  end

`ifndef SYNTHESIS
  a_div_rem_below_dur: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == eva_pkg::ST_DIV |-> rem_r < {1'b0, dur_r})
    else $error("divider remainder not below duration");

  a_prog_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    prog_r <= eva_pkg::ONE_Q16)
    else $error("progress above one");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == eva_pkg::ST_MUL1 || state_r == eva_pkg::ST_MUL2 ||
                  state_r == eva_pkg::ST_MUL3 || state_r == eva_pkg::ST_MUL4))
    else $error("multiplier finished outside a multiply step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != eva_pkg::ST_IDLE)
    else $error("accepted request did not start work");
`endif

endmodule
